>>> hw/rtl/mbw_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus write-registers frame builder.
package mbw_pkg;

    localparam int FRAME_LEN = 17;
    localparam int CRC_SPAN  = 15;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0] CNT_CRC_LO = CNT_W'(CRC_SPAN);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
    localparam logic [15:0] REG_COUNT      = 16'h0004;
    localparam logic [7:0]  BYTE_COUNT     = 8'd8;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h02;
    localparam logic [15:0] START_REG_RST  = 16'h0001;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_REG  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [15:0] fan_value;
        logic [15:0] pump_value;
        logic [15:0] piston_value;
        logic [15:0] lamp_value;
    } t_req;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_byte;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] start_register;
    } t_cfg;

    // One byte of CRC-16/MODBUS, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/mbw_req_if.sv
// Valid/ready channel carrying one write request.
interface mbw_req_if;
    import mbw_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mbw_byte_if.sv
// Valid/ready channel carrying one frame byte and its end marker.
interface mbw_byte_if;
    import mbw_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mbw_frame_tx.sv
// Frame stage: holds one request, sends its 17 bytes and folds the CRC in as bytes go out.
module mbw_frame_tx (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ld_valid,
    output logic          o_ld_ready,
    input  mbw_pkg::t_req i_ld_data,
    input  mbw_pkg::t_cfg i_cfg,
    mbw_byte_if.source    o_frame
);
    import mbw_pkg::*;

    logic             r_active;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_crc;
    t_req             r_vals;

    logic             n_active;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      n_crc;

    logic             beat;
    logic             ld;
    logic [7:0]       cur_byte;

    assign beat = o_frame.valid && o_frame.ready;
    assign o_ld_ready = !r_active || (beat && (r_cnt == CNT_LAST));
    assign ld = i_ld_valid && o_ld_ready;

    always_comb begin
        case (r_cnt)
            CNT_W'(0):  cur_byte = i_cfg.slave_address;
            CNT_W'(1):  cur_byte = FC_WRITE_MULTI;
            CNT_W'(2):  cur_byte = i_cfg.start_register[15:8];
            CNT_W'(3):  cur_byte = i_cfg.start_register[7:0];
            CNT_W'(4):  cur_byte = REG_COUNT[15:8];
            CNT_W'(5):  cur_byte = REG_COUNT[7:0];
            CNT_W'(6):  cur_byte = BYTE_COUNT;
            CNT_W'(7):  cur_byte = r_vals.fan_value[15:8];
            CNT_W'(8):  cur_byte = r_vals.fan_value[7:0];
            CNT_W'(9):  cur_byte = r_vals.pump_value[15:8];
            CNT_W'(10): cur_byte = r_vals.pump_value[7:0];
            CNT_W'(11): cur_byte = r_vals.piston_value[15:8];
            CNT_W'(12): cur_byte = r_vals.piston_value[7:0];
            CNT_W'(13): cur_byte = r_vals.lamp_value[15:8];
            CNT_W'(14): cur_byte = r_vals.lamp_value[7:0];
            CNT_W'(15): cur_byte = r_crc[7:0];
            default:    cur_byte = r_crc[15:8];
        endcase
    end

    assign o_frame.valid           = r_active;
    assign o_frame.data.frame_byte = cur_byte;
    assign o_frame.data.last_byte  = (r_cnt == CNT_LAST);

    always_comb begin
        n_active = r_active;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        if (ld) begin
            n_active = 1'b1;
            n_cnt    = '0;
            n_crc    = CRC_INIT;
        end else if (beat) begin
            if (r_cnt == CNT_LAST) begin
                n_active = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
            // The CRC covers every byte before the CRC itself.
            if (r_cnt < CNT_CRC_LO) begin
                n_crc = crc_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
        end else begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_vals <= i_ld_data;
        end
    end

`ifndef ASSERT_OFF
    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |=> (r_active && (r_cnt == '0) && (r_crc == CRC_INIT)))
        else $error("frame load did not restart the byte counter and CRC");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && o_frame.data.last_byte && !i_ld_valid) |=> !o_frame.valid)
        else $error("frame kept sending after its last beat");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt <= CNT_LAST))
        else $error("byte counter ran past the frame end");

    a_no_early_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !(beat && (r_cnt == CNT_LAST))) |-> !o_ld_ready)
        else $error("new request taken in the middle of a frame");
`endif

endmodule

>>> hw/rtl/modbus_write_regs_frame_builder.sv
// Top level of the Modbus RTU write-multiple-registers frame builder.
//
//  channel   dir  beat payload
//  i_req     in   fan_value, pump_value, piston_value, lamp_value (16 bit each)
//  o_frame   out  frame_byte (8 bit), last_byte (1 bit, set on the CRC high byte)
//  i_cfg_*   in   write port: index 0 slave_address, index 1 start_register
//
// Each request yields 17 output beats, one beat per cycle while o_frame is ready.
// A request waits in a one-deep buffer while the previous frame is still going out,
// and moves into the frame stage in the cycle of that frame's last beat.
// A stall on o_frame holds the current byte; the CRC advances only on accepted beats.
// Reset is synchronous and active low; config returns to 2 and 1.
module modbus_write_regs_frame_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mbw_req_if.sink                       i_req,
    mbw_byte_if.source                    o_frame,
    input  logic                          i_cfg_we,
    input  logic [mbw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mbw_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import mbw_pkg::*;

    t_cfg r_cfg;
    logic r_pend_valid;
    t_req r_pend;
    logic ld_ready;
    logic req_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= SLAVE_ADDR_RST;
            r_cfg.start_register <= START_REG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLAVE_ADDR: r_cfg.slave_address  <= i_cfg_data[7:0];
                CFG_START_REG:  r_cfg.start_register <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = !r_pend_valid;
    assign req_beat    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (req_beat) begin
            r_pend_valid <= 1'b1;
        end else if (ld_ready) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_beat) begin
            r_pend <= i_req.data;
        end
    end

    mbw_frame_tx u_frame_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_valid (r_pend_valid),
        .o_ld_ready (ld_ready),
        .i_ld_data  (r_pend),
        .i_cfg      (r_cfg),
        .o_frame    (o_frame)
    );

`ifndef ASSERT_OFF
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_beat |=> r_pend_valid)
        else $error("accepted request was not buffered");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && ld_ready) |=> !r_pend_valid)
        else $error("buffered request not released after hand-off");

    a_pend_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !ld_ready) |=> (r_pend_valid && $stable(r_pend)))
        else $error("buffered request lost while the frame stage was busy");
`endif

endmodule
